### rtl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg: shared types and constants of the look-at view matrix unit
// Item and result layouts, register indexes and fixed widths used across
// the normalizer, the row output stage and the top level.
// ----------------------------------------------------------------------------
package lavm_pkg;

  // Fixed field widths.
  localparam int COORD_W   = 32;
  localparam int ANGLE_W   = 16;
  localparam int UP_W      = 18;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the write port.
  localparam logic [CFG_IDX_W-1:0] CFG_UP_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Z      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_MODE = 2'd3;

  // Normalized magnitudes are brought to NRM_LEN_W bits with the top bit at NRM_TOP.
  localparam int NRM_LEN_W = 30;
  localparam int NRM_TOP   = 29;

  // Angle band limits in degrees.
  localparam int DEG_TURN          = 360;
  localparam int DEG_QUARTER       = 90;
  localparam int DEG_THREE_QUARTER = 270;

  // Row number of the constant bottom row.
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [ANGLE_W-1:0] orbit_elevation_deg;
    logic signed [ANGLE_W-1:0] free_pitch_deg;
  } item_t;

  typedef struct packed {
    logic [1:0]                row_index;
    logic signed [COORD_W-1:0] col0;
    logic signed [COORD_W-1:0] col1;
    logic signed [COORD_W-1:0] col2;
    logic signed [COORD_W-1:0] col3;
    logic                      last_row;
    logic                      degenerate;
  } result_t;

endpackage

### rtl/lavm_norm.sv
// ----------------------------------------------------------------------------
// lavm_norm: pipelined 3-vector normalizer
// Scales the magnitudes to a fixed range, takes the integer square root of
// the sum of squares one bit per stage, then divides each component by the
// length one quotient bit per stage with rounding. Side data rides along.
// ----------------------------------------------------------------------------
module lavm_norm #(
  parameter int W         = 33,
  parameter int FRAC_BITS = 16,
  parameter int SW        = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [W-1:0]         in_vec [3],
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_vec [3],
  output logic                        out_zero,
  output logic [SW-1:0]               out_side
);

  localparam int AXW   = FRAC_BITS + 2;
  localparam int LW    = lavm_pkg::NRM_LEN_W;
  localparam int XW    = W + LW;
  localparam int SHW   = $clog2(W + LW + 1);
  localparam int SQW   = 2 * LW + 4;
  localparam int STEPS = LW + 2;
  localparam int RTW   = LW + 2;
  localparam int QW    = FRAC_BITS + 1;
  localparam int NW    = LW + FRAC_BITS + 1;
  localparam int DW    = RTW + FRAC_BITS + 1;
  localparam int LAT   = STEPS + QW + 8;
  localparam logic [SHW-1:0] TOP = SHW'(lavm_pkg::NRM_TOP);

  // Stage 1: magnitudes and signs.
  logic [W-1:0] s1_mg [3];
  logic [2:0]   s1_sgn;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_mg[i]  <= in_vec[i][W-1] ? W'(-in_vec[i]) : W'(in_vec[i]);
      s1_sgn[i] <= in_vec[i][W-1];
    end
  end

  // Stage 2: largest magnitude.
  logic [W-1:0] mx;
  logic [W-1:0] s2_mg [3];
  logic [W-1:0] s2_mx;
  logic [2:0]   s2_sgn;

  always_comb begin
    mx = s1_mg[0];
    if (s1_mg[1] > mx) begin
      mx = s1_mg[1];
    end
    if (s1_mg[2] > mx) begin
      mx = s1_mg[2];
    end
  end

  always_ff @(posedge clk) begin
    s2_mg  <= s1_mg;
    s2_mx  <= mx;
    s2_sgn <= s1_sgn;
  end

  // Stage 3: leading one position and the scaling shift.
  logic [SHW-1:0] msb;
  logic [W-1:0]   s3_mg [3];
  logic [2:0]     s3_sgn;
  logic           s3_zero;
  logic           s3_right;
  logic [SHW-1:0] s3_amt;

  always_comb begin
    msb = '0;
    for (int b = 0; b < W; b++) begin
      if (s2_mx[b]) begin
        msb = SHW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_mg    <= s2_mg;
    s3_sgn   <= s2_sgn;
    s3_zero  <= (s2_mx == '0);
    s3_right <= (msb > TOP);
    s3_amt   <= (msb > TOP) ? msb - TOP : TOP - msb;
  end

  // Stage 4: scaled magnitudes, truncated on a right shift.
  logic [XW-1:0] wide [3];
  logic [LW-1:0] s4_mg [3];
  logic [2:0]    s4_sgn;
  logic          s4_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = s3_right ? (XW'(s3_mg[i]) >> s3_amt) : (XW'(s3_mg[i]) << s3_amt);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_mg[i] <= wide[i][LW-1:0];
    end
    s4_sgn  <= s3_sgn;
    s4_zero <= s3_zero;
  end

  // Stage 5: squares.
  logic [2*LW-1:0] s5_sq [3];
  logic [LW-1:0]   s5_mg [3];
  logic [2:0]      s5_sgn;
  logic            s5_zero;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s5_sq[i] <= s4_mg[i] * s4_mg[i];
    end
    s5_mg   <= s4_mg;
    s5_sgn  <= s4_sgn;
    s5_zero <= s4_zero;
  end

  // Stage 6 (square root slot 0): sum of squares, root cleared.
  logic [SQW-1:0] sq_n    [STEPS+1];
  logic [SQW-1:0] sq_r    [STEPS+1];
  logic [LW-1:0]  sq_mg   [STEPS+1][3];
  logic [2:0]     sq_sgn  [STEPS+1];
  logic           sq_zero [STEPS+1];

  always_ff @(posedge clk) begin
    sq_n[0]    <= SQW'(s5_sq[0]) + SQW'(s5_sq[1]) + SQW'(s5_sq[2]);
    sq_r[0]    <= '0;
    sq_mg[0]   <= s5_mg;
    sq_sgn[0]  <= s5_sgn;
    sq_zero[0] <= s5_zero;
  end

  // Square root: one result bit per stage, starting at the top bit pair.
  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (STEPS - 1 - k));
    logic [SQW-1:0] trial;

    assign trial = sq_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (sq_n[k] >= trial) begin
        sq_n[k+1] <= sq_n[k] - trial;
        sq_r[k+1] <= (sq_r[k] >> 1) + BIT;
      end else begin
        sq_n[k+1] <= sq_n[k];
        sq_r[k+1] <= sq_r[k] >> 1;
      end
      sq_mg[k+1]   <= sq_mg[k];
      sq_sgn[k+1]  <= sq_sgn[k];
      sq_zero[k+1] <= sq_zero[k];
    end
  end

  // Numerator stage: scaled magnitude plus half the length for rounding.
  logic [NW-1:0]  dv_rem  [QW+1][3];
  logic [QW-1:0]  dv_q    [QW+1][3];
  logic [RTW-1:0] dv_len  [QW+1];
  logic [2:0]     dv_sgn  [QW+1];
  logic           dv_zero [QW+1];
  logic [RTW-1:0] len;

  assign len = sq_r[STEPS][RTW-1:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= (NW'(sq_mg[STEPS][i]) << FRAC_BITS) + NW'(len >> 1);
      dv_q[0][i]   <= '0;
    end
    dv_len[0]  <= len;
    dv_sgn[0]  <= sq_sgn[STEPS];
    dv_zero[0] <= sq_zero[STEPS];
  end

  // Restoring division: one quotient bit per stage for all three components.
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int J = QW - 1 - s;
    logic [DW-1:0] dsh;

    assign dsh = DW'(dv_len[s]) << J;

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (DW'(dv_rem[s][i]) >= dsh) begin
          dv_rem[s+1][i] <= NW'(DW'(dv_rem[s][i]) - dsh);
          dv_q[s+1][i]   <= dv_q[s][i] | (QW'(1) << J);
        end else begin
          dv_rem[s+1][i] <= dv_rem[s][i];
          dv_q[s+1][i]   <= dv_q[s][i];
        end
      end
      dv_len[s+1]  <= dv_len[s];
      dv_sgn[s+1]  <= dv_sgn[s];
      dv_zero[s+1] <= dv_zero[s];
    end
  end

  // Output stage: restore signs, force zero for an all-zero vector.
  logic signed [AXW-1:0] qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = signed'(AXW'(dv_q[QW][i]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[QW]) begin
        out_vec[i] <= '0;
      end else begin
        out_vec[i] <= dv_sgn[QW][i] ? -qs[i] : qs[i];
      end
    end
    out_zero <= dv_zero[QW];
  end

  // Valid bits and side data travel alongside the data stages.
  logic [LAT-1:0] vl;
  logic [SW-1:0]  sd [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else begin
      vl <= {vl[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sd[0] <= in_side;
    for (int k = 1; k < LAT; k++) begin
      sd[k] <= sd[k-1];
    end
  end

  assign out_valid = vl[LAT-1];
  assign out_side  = sd[LAT-1];

endmodule

### rtl/lavm_cross.sv
// ----------------------------------------------------------------------------
// lavm_cross: two-stage cross product
// Six registered products, then the three differences. Side data rides along.
// ----------------------------------------------------------------------------
module lavm_cross #(
  parameter int AW = 19,
  parameter int BW = 18,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic signed [AW-1:0]   a [3],
  input  logic signed [BW-1:0]   b [3],
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  output logic signed [AW+BW:0]  out_vec [3],
  output logic [SW-1:0]          out_side
);

  localparam int PW = AW + BW;
  localparam int CW = AW + BW + 1;

  logic signed [PW-1:0] p [6];
  logic [SW-1:0]        side1;
  logic                 v1;

  // Stage 1: partial products.
  always_ff @(posedge clk) begin
    p[0]  <= PW'(a[1]) * PW'(b[2]);
    p[1]  <= PW'(a[2]) * PW'(b[1]);
    p[2]  <= PW'(a[2]) * PW'(b[0]);
    p[3]  <= PW'(a[0]) * PW'(b[2]);
    p[4]  <= PW'(a[0]) * PW'(b[1]);
    p[5]  <= PW'(a[1]) * PW'(b[0]);
    side1 <= in_side;
  end

  // Stage 2: differences.
  always_ff @(posedge clk) begin
    out_vec[0] <= CW'(p[0]) - CW'(p[1]);
    out_vec[1] <= CW'(p[2]) - CW'(p[3]);
    out_vec[2] <= CW'(p[4]) - CW'(p[5]);
    out_side   <= side1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

endmodule

### rtl/lavm_rows.sv
// ----------------------------------------------------------------------------
// lavm_rows: translation column and row output
// Forms the three dot products with the eye point, rounds and saturates
// them, then sends the four matrix rows out one per cycle.
// ----------------------------------------------------------------------------
module lavm_rows #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [FRAC_BITS+1:0] ax [3][3],
  input  logic signed [31:0]          eye [3],
  input  logic                        deg,
  output logic                        done,
  output lavm_pkg::result_t           result
);

  localparam int AXW = FRAC_BITS + 2;
  localparam int PW  = AXW + lavm_pkg::COORD_W;
  localparam int SMW = PW + 2;
  localparam int MW  = SMW + 1;
  localparam logic [MW-1:0] HALF = MW'(1) << (FRAC_BITS - 1);
  localparam logic [MW-1:0] POS_MAX = MW'(32'h7fff_ffff);
  localparam logic [MW-1:0] NEG_MAG = MW'(1) << 31;
  localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  logic signed [AXW-1:0] ax_p  [4][3][3];
  logic                  deg_p [4];
  logic [3:0]            v_p;

  // Axes and flag follow the four arithmetic stages.
  always_ff @(posedge clk) begin
    ax_p[0]  <= ax;
    deg_p[0] <= deg;
    for (int k = 1; k < 4; k++) begin
      ax_p[k]  <= ax_p[k-1];
      deg_p[k] <= deg_p[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= '0;
    end else begin
      v_p <= {v_p[2:0], in_valid};
    end
  end

  // Stage 1: products of axis components with the eye point.
  logic signed [PW-1:0] pr [3][3];

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) begin
        pr[a][i] <= PW'(ax[a][i]) * PW'(eye[i]);
      end
    end
  end

  // Stage 2: exact dot products.
  logic signed [SMW-1:0] sm [3];

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      sm[a] <= SMW'(pr[a][0]) + SMW'(pr[a][1]) + SMW'(pr[a][2]);
    end
  end

  // Stage 3: magnitude plus half an output step.
  logic [MW-1:0] mr  [3];
  logic [2:0]    neg;

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      mr[a]  <= (sm[a][SMW-1] ? MW'(SMW'(-sm[a])) : MW'(SMW'(sm[a]))) + HALF;
      neg[a] <= sm[a][SMW-1];
    end
  end

  // Stage 4: scale down, negate and saturate.
  logic [MW-1:0]      rnd [3];
  logic signed [31:0] tr  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rnd[a] = mr[a] >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (neg[a]) begin
        tr[a] <= (rnd[a] > POS_MAX) ? 32'sh7fff_ffff : signed'(rnd[a][31:0]);
      end else begin
        tr[a] <= (rnd[a] > NEG_MAG) ? 32'sh8000_0000 : -signed'(rnd[a][31:0]);
      end
    end
  end

  // Row sequencer: a finished item is held and sent out one row per cycle.
  logic signed [AXW-1:0] hold_ax [3][3];
  logic signed [31:0]    hold_t  [3];
  logic                  hold_deg;
  logic [1:0]            cnt;
  logic                  act;

  always_ff @(posedge clk) begin
    if (rst) begin
      act  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= act;
      if (v_p[3]) begin
        act <= 1'b1;
        cnt <= '0;
      end else if (act) begin
        cnt <= cnt + 2'd1;
        if (cnt == lavm_pkg::ROW_LAST) begin
          act <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v_p[3]) begin
      hold_ax  <= ax_p[3];
      hold_t   <= tr;
      hold_deg <= deg_p[3];
    end
    result.row_index  <= cnt;
    result.last_row   <= (cnt == lavm_pkg::ROW_LAST);
    result.degenerate <= hold_deg;
    if (cnt == lavm_pkg::ROW_LAST) begin
      result.col0 <= '0;
      result.col1 <= '0;
      result.col2 <= '0;
      result.col3 <= ONE;
    end else if (hold_deg) begin
      result.col0 <= '0;
      result.col1 <= '0;
      result.col2 <= '0;
      result.col3 <= '0;
    end else begin
      result.col0 <= 32'(hold_ax[cnt][0]);
      result.col1 <= 32'(hold_ax[cnt][1]);
      result.col2 <= 32'(hold_ax[cnt][2]);
      result.col3 <= hold_t[cnt];
    end
  end

endmodule

### rtl/look_at_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit: left-handed look-at view matrix, fixed point
// Takes an eye point, a target point and two angles per item and returns
// the four rows of the view matrix.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. After
//   taking one, busy stays high while the gap counter runs down, so items
//   cannot enter faster than the result port, which carries one matrix row
//   per cycle, can send out their four rows.
//   Row 0 appears on result with done high, and rows 1 to 3 follow in
//   consecutive cycles. Each row is valid for exactly one cycle; the
//   receiver cannot hold it off, and the pipeline never needs to stop.
//   The datapath is a fixed pipeline: three normalizers (square root and
//   division one bit per stage), two cross products and the translation
//   stages. Several items are in flight at once.
//   Registers (world up vector and angle select) are written through
//   cfg_we/cfg_index/cfg_data; the user must write them only while no
//   item is in flight, as the block itself does not enforce this.
//   Reset (synchronous, rst high) empties the pipeline, clears busy and
//   loads the world up vector (0, 1.0, 0) with orbit angle selected.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  lavm_pkg::item_t                     item,
  input  logic                                cfg_we,
  input  logic [lavm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lavm_pkg::UP_W-1:0]           cfg_data,
  output logic                                done,
  output lavm_pkg::result_t                   result
);

  localparam int CW   = lavm_pkg::COORD_W;
  localparam int AXW  = FRAC_BITS + 2;
  localparam int UPE  = lavm_pkg::UP_W + 1;
  localparam int DW   = CW + 1;
  localparam int C1W  = UPE + AXW + 1;
  localparam int C2W  = 2 * AXW + 1;
  localparam int EYW  = 3 * CW;
  localparam int S1W  = EYW + 1;
  localparam int S2W  = EYW + 3 * AXW + 1;
  localparam int S3W  = EYW + 6 * AXW + 1;
  localparam logic signed [lavm_pkg::UP_W-1:0] UP_Y_RST =
    lavm_pkg::UP_W'(64'd1 << FRAC_BITS);
  localparam logic [lavm_pkg::ANGLE_W-1:0] QUARTER =
    lavm_pkg::ANGLE_W'(lavm_pkg::DEG_QUARTER);
  localparam logic [lavm_pkg::ANGLE_W-1:0] THREE_QUARTER =
    lavm_pkg::ANGLE_W'(lavm_pkg::DEG_THREE_QUARTER);

  // Configuration registers.
  logic signed [lavm_pkg::UP_W-1:0] up [3];
  logic                             free_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      up[0]     <= '0;
      up[1]     <= UP_Y_RST;
      up[2]     <= '0;
      free_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lavm_pkg::CFG_UP_X:      up[0] <= cfg_data;
        lavm_pkg::CFG_UP_Y:      up[1] <= cfg_data;
        lavm_pkg::CFG_UP_Z:      up[2] <= cfg_data;
        lavm_pkg::CFG_FREE_MODE: free_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Entry spacing: busy holds off a new item until gap has counted down to zero.
  logic [1:0] gap;
  logic       accept;

  assign busy   = (gap != '0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else if (accept) begin
      gap <= lavm_pkg::ROW_LAST;
    end else if (gap != '0) begin
      gap <= gap - 2'd1;
    end
  end

  // Active angle reduced modulo a full turn by shifted subtractions.
  logic signed [lavm_pkg::ANGLE_W-1:0] ang;
  logic [lavm_pkg::ANGLE_W-1:0]        amod;
  logic                                flip;

  always_comb begin
    ang  = free_mode ? item.free_pitch_deg : item.orbit_elevation_deg;
    amod = ang[lavm_pkg::ANGLE_W-1] ? lavm_pkg::ANGLE_W'(-ang) : lavm_pkg::ANGLE_W'(ang);
    for (int k = 6; k >= 0; k--) begin
      if (amod >= (lavm_pkg::ANGLE_W'(lavm_pkg::DEG_TURN) << k)) begin
        amod = amod - (lavm_pkg::ANGLE_W'(lavm_pkg::DEG_TURN) << k);
      end
    end
    flip = (amod >= QUARTER) && (amod <= THREE_QUARTER);
  end

  // Entry stage: direction vector, eye point and up-vector sign.
  logic signed [DW-1:0] s0_d   [3];
  logic signed [CW-1:0] s0_eye [3];
  logic                 s0_flip;
  logic                 s0_valid;

  always_ff @(posedge clk) begin
    s0_d[0]   <= DW'(item.target_x) - DW'(item.eye_x);
    s0_d[1]   <= DW'(item.target_y) - DW'(item.eye_y);
    s0_d[2]   <= DW'(item.target_z) - DW'(item.eye_z);
    s0_eye[0] <= item.eye_x;
    s0_eye[1] <= item.eye_y;
    s0_eye[2] <= item.eye_z;
    s0_flip   <= flip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
  end

  // Forward axis.
  logic signed [AXW-1:0] f1 [3];
  logic                  n1_valid;
  logic                  n1_zero;
  logic [S1W-1:0]        n1_side;

  lavm_norm #(.W(DW), .FRAC_BITS(FRAC_BITS), .SW(S1W)) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_valid),
    .in_vec    (s0_d),
    .in_side   ({s0_flip, s0_eye[0], s0_eye[1], s0_eye[2]}),
    .out_valid (n1_valid),
    .out_vec   (f1),
    .out_zero  (n1_zero),
    .out_side  (n1_side)
  );

  // Up vector with the band sign applied, crossed with forward.
  logic signed [UPE-1:0] up_e [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up_e[i] = n1_side[EYW] ? -UPE'(up[i]) : UPE'(up[i]);
    end
  end

  logic signed [C1W-1:0] c1 [3];
  logic                  x1_valid;
  logic [S2W-1:0]        x1_side;

  lavm_cross #(.AW(UPE), .BW(AXW), .SW(S2W)) u_cross_right (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (n1_valid),
    .a         (up_e),
    .b         (f1),
    .in_side   ({n1_zero, f1[0], f1[1], f1[2], n1_side[EYW-1:0]}),
    .out_valid (x1_valid),
    .out_vec   (c1),
    .out_side  (x1_side)
  );

  // Right axis.
  logic signed [AXW-1:0] r2 [3];
  logic                  n2_valid;
  logic                  n2_zero;
  logic [S2W-1:0]        n2_side;

  lavm_norm #(.W(C1W), .FRAC_BITS(FRAC_BITS), .SW(S2W)) u_norm_right (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (x1_valid),
    .in_vec    (c1),
    .in_side   (x1_side),
    .out_valid (n2_valid),
    .out_vec   (r2),
    .out_zero  (n2_zero),
    .out_side  (n2_side)
  );

  // Forward crossed with right.
  logic signed [AXW-1:0] f2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f2[i] = n2_side[EYW + (2 - i) * AXW +: AXW];
    end
  end

  logic signed [C2W-1:0] c2 [3];
  logic                  x2_valid;
  logic [S3W-1:0]        x2_side;

  lavm_cross #(.AW(AXW), .BW(AXW), .SW(S3W)) u_cross_up (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (n2_valid),
    .a         (f2),
    .b         (r2),
    .in_side   ({n2_side[S2W-1] | n2_zero, n2_side[S2W-2:EYW],
                 r2[0], r2[1], r2[2], n2_side[EYW-1:0]}),
    .out_valid (x2_valid),
    .out_vec   (c2),
    .out_side  (x2_side)
  );

  // Third axis.
  logic signed [AXW-1:0] v3 [3];
  logic                  n3_valid;
  logic                  n3_zero;
  logic [S3W-1:0]        n3_side;

  lavm_norm #(.W(C2W), .FRAC_BITS(FRAC_BITS), .SW(S3W)) u_norm_up (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (x2_valid),
    .in_vec    (c2),
    .in_side   (x2_side),
    .out_valid (n3_valid),
    .out_vec   (v3),
    .out_zero  (n3_zero),
    .out_side  (n3_side)
  );

  // Rows: right, third axis, forward.
  logic signed [AXW-1:0] axes [3][3];
  logic signed [CW-1:0]  eye3 [3];
  logic                  deg3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axes[0][i] = n3_side[EYW + (2 - i) * AXW +: AXW];
      axes[1][i] = v3[i];
      axes[2][i] = n3_side[EYW + 3 * AXW + (2 - i) * AXW +: AXW];
      eye3[i]    = n3_side[(2 - i) * CW +: CW];
    end
    deg3 = n3_side[S3W-1] | n3_zero;
  end

  lavm_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
    .clk      (clk),
    .rst      (rst),
    .in_valid (n3_valid),
    .ax       (axes),
    .eye      (eye3),
    .deg      (deg3),
    .done     (done),
    .result   (result)
  );

  // Taking an item always raises busy for the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an item was taken");

  // Rows of one matrix come in consecutive cycles with rising row numbers.
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last_row) |=>
      (done && result.row_index == $past(result.row_index) + 2'd1))
    else $error("matrix rows not sent back to back in order");

  // The degenerate flag is the same on all rows of a matrix.
  a_deg_steady: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last_row) |=> $stable(result.degenerate))
    else $error("degenerate flag changed within one matrix");

endmodule
